// ===== design/alrs_pkg.sv =====
package alrs_pkg;

  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned Q_DEPTH   = 3;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [24:0] PART_LEN_RST = 25'd65536;
  localparam logic [7:0]  ERASED_RST   = 8'hFF;

  // header byte offsets
  localparam logic [3:0] HB_TYPE   = 4'd0;
  localparam logic [3:0] HB_RSVD   = 4'd1;
  localparam logic [3:0] HB_LEN_LO = 4'd2;
  localparam logic [3:0] HB_LEN_HI = 4'd3;
  localparam logic [3:0] HB_SEQ0   = 4'd4;
  localparam logic [3:0] HB_SEQ3   = 4'd7;
  localparam logic [3:0] HB_CRC0   = 4'd8;
  localparam logic [3:0] HB_LAST   = 4'd11;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD
  } alrs_phase_t;

  typedef enum logic [2:0] {
    CAUSE_ERASED,
    CAUSE_BAD_HEADER,
    CAUSE_OVERRUN,
    CAUSE_CRC,
    CAUSE_END
  } alrs_cause_t;

  typedef enum logic [0:0] {
    CFG_PARTITION_SIZE,
    CFG_ERASED_MARKER
  } alrs_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rec_type;
    logic [31:0] rec_seq;
    logic [8:0]  rec_len;
    logic [23:0] rec_offset;
    logic [24:0] end_pointer;
    logic [31:0] next_sequence;
    logic [24:0] valid_count;
    alrs_cause_t stop_cause;
    logic        last;
  } alrs_result_t;

  typedef struct packed {
    logic first;
    logic second;
  } alrs_push_t;

  function automatic logic [31:0] alrs_crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/alrs_out_queue.sv =====
module alrs_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alrs_pkg::alrs_push_t push,
  input  alrs_pkg::alrs_result_t item0,
  input  alrs_pkg::alrs_result_t item1,
  output logic                 room,
  output logic                 head_valid,
  output alrs_pkg::alrs_result_t head_item,
  input  logic                 pop
);
  import alrs_pkg::*;

  alrs_result_t entry_r [Q_DEPTH];
  logic [1:0] head_r, head_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] tail0, tail1;

  function automatic logic [1:0] q_add(input logic [1:0] p, input logic [1:0] n);
    logic [2:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= 3'(Q_DEPTH)) begin
      s = s - 3'(Q_DEPTH);
    end
    return s[1:0];
  endfunction

  assign tail0 = q_add(head_r, count_r);
  assign tail1 = q_add(tail0, 2'd1);

  // two results may land in one request, so keep two slots free
  assign room       = (count_r <= 2'd1);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = entry_r[head_r];

  always_comb begin
    head_nxt  = pop ? q_add(head_r, 2'd1) : head_r;
    count_nxt = count_r + 2'(push.first) + 2'(push.second) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < Q_DEPTH; e++) begin
      if (push.first && tail0 == 2'(e)) begin
        entry_r[e] <= item0;
      end
      if (push.second && tail1 == 2'(e)) begin
        entry_r[e] <= item1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first)
    else $error("second result pushed without first");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= 2'd2) |-> !push.first)
    else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty result queue");
  a_record_then_summary: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> (!item0.kind && item1.kind && item1.last))
    else $error("double push is not record plus summary");
`endif

endmodule

// ===== design/append_log_record_scanner.sv =====
// Append log scanner: walks a log partition one flash byte per request.
// Input channel (in_valid/in_ready): in_mode 0 starts a scan at offset 0,
// in_mode 1 delivers the next flash byte in in_byte_value. Bytes with no
// scan running are dropped silently.
// Output channel (out_valid/out_ready): one record result per valid record
// (kind 0), then a summary (kind 1, last 1) with write pointer, next
// sequence, record count and stop cause.
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 partition
// size, 1 erased marker); write only while no scan is in flight.
// Throughput: one byte per cycle. The CRC-32 byte update, header capture
// and all checks sit between the state registers and a 3-entry result
// queue. Results are registered in the queue before they reach the outputs;
// a record closing at partition end queues two results.
// in_ready is low whenever two or more results are waiting, so a stalled
// receiver back-pressures the byte stream with no loss.
// Reset: registers take their defaults (partition size 65536, marker 0xFF),
// the scanner idles and the queue empties.
module append_log_record_scanner #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [7:0]            in_byte_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_rec_type,
  output logic [31:0]           out_rec_seq,
  output logic [8:0]            out_rec_len,
  output logic [23:0]           out_rec_offset,
  output logic [24:0]           out_end_pointer,
  output logic [31:0]           out_next_sequence,
  output logic [24:0]           out_valid_count,
  output alrs_pkg::alrs_cause_t out_stop_cause,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  alrs_pkg::alrs_cfg_t   cfg_index,
  input  logic [24:0]           cfg_wdata
);
  import alrs_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IDX_W = (LEN_W > 4) ? LEN_W : 4;

  logic [24:0] part_len_r;
  logic [7:0]  erased_r;

  alrs_phase_t phase_r, phase_nxt;
  logic [24:0] sp_r, sp_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]  hold_type_r, hold_type_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0] hold_len_r, hold_len_nxt;
  logic [31:0] hold_seq_r, hold_seq_nxt;
  logic [31:0] hold_crc_r, hold_crc_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] nsv_r, nsv_nxt;
  logic [24:0] total_r, total_nxt;

  logic         in_fire;
  logic [3:0]   hdr_i;
  logic [31:0]  crc_upd;
  logic [15:0]  len16;
  logic [15:0]  hold_len16;
  logic [IDX_W-1:0] idx_inc;
  logic [24:0]  sp_fin;
  logic         finish;
  alrs_push_t   push;
  alrs_result_t item0, item1, head_item;
  logic         q_room;

  function automatic alrs_result_t summary(input logic [24:0] sp, input logic [31:0] nsv,
                                           input logic [24:0] total, input alrs_cause_t cause);
    alrs_result_t r;
    r               = '0;
    r.kind          = 1'b1;
    r.end_pointer   = sp;
    r.next_sequence = nsv;
    r.valid_count   = total;
    r.stop_cause    = cause;
    r.last          = 1'b1;
    return r;
  endfunction

  assign in_ready   = q_room;
  assign in_fire    = in_valid && in_ready;
  assign hdr_i      = idx_r[3:0];
  assign crc_upd    = alrs_crc_byte(crc_r, in_byte_value);
  assign len16      = {in_byte_value, len_lo_r};
  assign hold_len16 = 16'(hold_len_r);
  assign idx_inc    = idx_r + 1'b1;
  assign sp_fin     = sp_r + 25'(HDR_BYTES) + 25'(hold_len_r);

  always_comb begin
    phase_nxt     = phase_r;
    sp_nxt        = sp_r;
    idx_nxt       = idx_r;
    hold_type_nxt = hold_type_r;
    len_lo_nxt    = len_lo_r;
    hold_len_nxt  = hold_len_r;
    hold_seq_nxt  = hold_seq_r;
    hold_crc_nxt  = hold_crc_r;
    crc_nxt       = crc_r;
    nsv_nxt       = nsv_r;
    total_nxt     = total_r;
    finish        = 1'b0;
    push          = '0;
    item0         = '0;
    item1         = '0;

    if (in_fire) begin
      if (!in_mode) begin
        sp_nxt        = '0;
        nsv_nxt       = 32'd1;
        total_nxt     = '0;
        hold_type_nxt = '0;
        hold_len_nxt  = '0;
        hold_seq_nxt  = '0;
        hold_crc_nxt  = '0;
        phase_nxt     = PH_HEADER;
        idx_nxt       = '0;
        crc_nxt       = CRC_INIT;
        if (26'(HDR_BYTES) > {1'b0, part_len_r}) begin
          item0      = summary('0, 32'd1, '0, CAUSE_END);
          push.first = 1'b1;
          phase_nxt  = PH_IDLE;
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr_i < HB_CRC0) begin
              crc_nxt = crc_upd;
            end
            idx_nxt = idx_inc;
            case (hdr_i) inside
              HB_TYPE: begin
                hold_type_nxt = in_byte_value;
                if (in_byte_value == erased_r) begin
                  item0      = summary(sp_r, nsv_r, total_r, CAUSE_ERASED);
                  push.first = 1'b1;
                  phase_nxt  = PH_IDLE;
                end
              end
              HB_RSVD: begin
                if (in_byte_value != 8'd0) begin
                  item0      = summary(sp_r, nsv_r, total_r, CAUSE_BAD_HEADER);
                  push.first = 1'b1;
                  phase_nxt  = PH_IDLE;
                end
              end
              HB_LEN_LO: len_lo_nxt = in_byte_value;
              HB_LEN_HI: begin
                hold_len_nxt = LEN_W'(len16);
                if (len16 > 16'(MAX_PAYLOAD)) begin
                  item0      = summary(sp_r, nsv_r, total_r, CAUSE_BAD_HEADER);
                  push.first = 1'b1;
                  phase_nxt  = PH_IDLE;
                end else if ({1'b0, sp_r} + 26'(HDR_BYTES) + 26'(len16)
                             > {1'b0, part_len_r}) begin
                  item0      = summary(sp_r, nsv_r, total_r, CAUSE_OVERRUN);
                  push.first = 1'b1;
                  phase_nxt  = PH_IDLE;
                end
              end
              [HB_SEQ0:HB_SEQ3]: hold_seq_nxt[8*hdr_i[1:0] +: 8] = in_byte_value;
              default: begin
                hold_crc_nxt[8*hdr_i[1:0] +: 8] = in_byte_value;
                if (hdr_i == HB_LAST) begin
                  idx_nxt = '0;
                  if (hold_len_r == '0) begin
                    finish = 1'b1;
                  end else begin
                    phase_nxt = PH_PAYLOAD;
                  end
                end
              end
            endcase
          end
          PH_PAYLOAD: begin
            crc_nxt = crc_upd;
            idx_nxt = idx_inc;
            if (idx_inc >= IDX_W'(hold_len_r)) begin
              finish = 1'b1;
            end
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
    end

    if (finish) begin
      push.first = 1'b1;
      if (~crc_nxt != hold_crc_nxt) begin
        item0     = summary(sp_r, nsv_r, total_r, CAUSE_CRC);
        phase_nxt = PH_IDLE;
      end else begin
        item0.rec_type   = hold_type_r;
        item0.rec_seq    = hold_seq_r;
        item0.rec_len    = hold_len16[8:0];
        item0.rec_offset = sp_r[23:0];
        total_nxt        = total_r + 25'd1;
        if (hold_seq_r >= nsv_r) begin
          nsv_nxt = hold_seq_r + 32'd1;
        end
        sp_nxt = sp_fin;
        if ({1'b0, sp_fin} + 26'(HDR_BYTES) > {1'b0, part_len_r}) begin
          item1       = summary(sp_fin, nsv_nxt, total_nxt, CAUSE_END);
          push.second = 1'b1;
          phase_nxt   = PH_IDLE;
        end else begin
          phase_nxt = PH_HEADER;
          idx_nxt   = '0;
          crc_nxt   = CRC_INIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_len_r  <= PART_LEN_RST;
      erased_r    <= ERASED_RST;
      phase_r     <= PH_IDLE;
      sp_r        <= '0;
      idx_r       <= '0;
      hold_type_r <= '0;
      len_lo_r    <= '0;
      hold_len_r  <= '0;
      hold_seq_r  <= '0;
      hold_crc_r  <= '0;
      crc_r       <= CRC_INIT;
      nsv_r       <= 32'd1;
      total_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PARTITION_SIZE: part_len_r <= cfg_wdata;
          CFG_ERASED_MARKER:  erased_r   <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      sp_r        <= sp_nxt;
      idx_r       <= idx_nxt;
      hold_type_r <= hold_type_nxt;
      len_lo_r    <= len_lo_nxt;
      hold_len_r  <= hold_len_nxt;
      hold_seq_r  <= hold_seq_nxt;
      hold_crc_r  <= hold_crc_nxt;
      crc_r       <= crc_nxt;
      nsv_r       <= nsv_nxt;
      total_r     <= total_nxt;
    end
  end

  alrs_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .item0      (item0),
    .item1      (item1),
    .room       (q_room),
    .head_valid (out_valid),
    .head_item  (head_item),
    .pop        (out_valid && out_ready)
  );

  assign out_kind          = head_item.kind;
  assign out_rec_type      = head_item.rec_type;
  assign out_rec_seq       = head_item.rec_seq;
  assign out_rec_len       = head_item.rec_len;
  assign out_rec_offset    = head_item.rec_offset;
  assign out_end_pointer   = head_item.end_pointer;
  assign out_next_sequence = head_item.next_sequence;
  assign out_valid_count   = head_item.valid_count;
  assign out_stop_cause    = head_item.stop_cause;
  assign out_last          = head_item.last;

`ifndef ASSERT_OFF
  a_summary_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && push.first && (push.second ? item1.kind : item0.kind)) |=> phase_r == PH_IDLE)
    else $error("scanner still running after summary");
  a_idle_no_results: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode && phase_r == PH_IDLE) |-> !push.first)
    else $error("result from byte while idle");
  a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (hold_len_r != '0 && hold_len16 <= 16'(MAX_PAYLOAD)))
    else $error("payload phase with bad length");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
  import alrs_pkg::*;

  localparam int unsigned PAYLOAD_MAX = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [7:0] in_byte_value = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [7:0] out_rec_type;
  logic [31:0] out_rec_seq;
  logic [8:0] out_rec_len;
  logic [23:0] out_rec_offset;
  logic [24:0] out_end_pointer;
  logic [31:0] out_next_sequence;
  logic [24:0] out_valid_count;
  alrs_cause_t out_stop_cause;
  logic out_last;
  logic cfg_we = 1'b0;
  alrs_cfg_t cfg_index = CFG_PARTITION_SIZE;
  logic [24:0] cfg_wdata = 25'd0;

  always #6 clk = ~clk;

  append_log_record_scanner #(.MAX_PAYLOAD(PAYLOAD_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_byte_value(in_byte_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_rec_type(out_rec_type), .out_rec_seq(out_rec_seq), .out_rec_len(out_rec_len),
    .out_rec_offset(out_rec_offset), .out_end_pointer(out_end_pointer),
    .out_next_sequence(out_next_sequence), .out_valid_count(out_valid_count),
    .out_stop_cause(out_stop_cause), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // scanner state as the testbench tracks it
  logic [24:0] part_len = PART_LEN_RST;
  logic [7:0] erase_mark = ERASED_RST;
  alrs_phase_t scan_st = PH_IDLE;
  logic [24:0] scan_ptr = 25'd0;
  int hdr_idx = 0;
  logic [7:0] rec_type_h = 8'd0;
  logic [15:0] rec_len_h = 16'd0;
  logic [31:0] rec_seq_h = 32'd0;
  logic [31:0] rec_crc = 32'd0;
  logic [31:0] crc_acc = CRC_INIT;
  logic [31:0] seq_next = 32'd1;
  logic [24:0] rec_total = 25'd0;

  alrs_result_t pending_res[$];
  int n_items = 0;
  int n_results = 0;
  int n_errors = 0;
  int cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;

  typedef struct {
    logic mode;
    logic [7:0] data;
    int typed;            // -1: predicted, 0: no result, 1: res below
    alrs_result_t res;
  } probe_t;
  probe_t probes[$];

  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic alrs_result_t stop_report(input alrs_cause_t c);
    alrs_result_t r;
    r = '0;
    r.kind = 1'b1;
    r.end_pointer = scan_ptr;
    r.next_sequence = seq_next;
    r.valid_count = rec_total;
    r.stop_cause = c;
    r.last = 1'b1;
    scan_st = PH_IDLE;
    return r;
  endfunction

  function automatic bit hdr_room();
    return 32'(scan_ptr) + HDR_BYTES <= 32'(part_len);
  endfunction

  function automatic void begin_header();
    scan_st = PH_HEADER;
    hdr_idx = 0;
    crc_acc = CRC_INIT;
  endfunction

  function automatic int close_record(output alrs_result_t r0, output alrs_result_t r1);
    r0 = '0;
    r1 = '0;
    if (~crc_acc != rec_crc) begin
      r0 = stop_report(CAUSE_CRC);
      return 1;
    end
    r0.rec_type = rec_type_h;
    r0.rec_seq = rec_seq_h;
    r0.rec_len = rec_len_h[8:0];
    r0.rec_offset = scan_ptr[23:0];
    rec_total = rec_total + 25'd1;
    if (rec_seq_h >= seq_next) seq_next = rec_seq_h + 32'd1;
    scan_ptr = 25'(32'(scan_ptr) + HDR_BYTES + 32'(rec_len_h));
    if (!hdr_room()) begin
      r1 = stop_report(CAUSE_END);
      return 2;
    end
    begin_header();
    return 1;
  endfunction

  // returns the number of results, or -1 when the byte is dropped
  function automatic int scan_step(input logic m, input logic [7:0] b,
                                   output alrs_result_t r0, output alrs_result_t r1);
    r0 = '0;
    r1 = '0;
    if (m == 1'b0) begin
      scan_ptr = 25'd0;
      seq_next = 32'd1;
      rec_total = 25'd0;
      rec_type_h = 8'd0;
      rec_len_h = 16'd0;
      rec_seq_h = 32'd0;
      rec_crc = 32'd0;
      begin_header();
      if (!hdr_room()) begin
        r0 = stop_report(CAUSE_END);
        return 1;
      end
      return 0;
    end
    case (scan_st)
      PH_HEADER: begin
        if (hdr_idx < HB_CRC0) crc_acc = crc32_step(crc_acc, b);
        case (hdr_idx)
          HB_TYPE: begin
            rec_type_h = b;
            if (b == erase_mark) begin
              r0 = stop_report(CAUSE_ERASED);
              return 1;
            end
          end
          HB_RSVD: begin
            if (b != 8'd0) begin
              r0 = stop_report(CAUSE_BAD_HEADER);
              return 1;
            end
          end
          HB_LEN_LO: rec_len_h = {8'd0, b};
          HB_LEN_HI: begin
            rec_len_h[15:8] = b;
            if (rec_len_h > PAYLOAD_MAX) begin
              r0 = stop_report(CAUSE_BAD_HEADER);
              return 1;
            end
            if (32'(scan_ptr) + HDR_BYTES + 32'(rec_len_h) > 32'(part_len)) begin
              r0 = stop_report(CAUSE_OVERRUN);
              return 1;
            end
          end
          default: begin
            if (hdr_idx <= HB_SEQ3) rec_seq_h[8*(hdr_idx-HB_SEQ0) +: 8] = b;
            else rec_crc[8*(hdr_idx-HB_CRC0) +: 8] = b;
          end
        endcase
        hdr_idx++;
        if (hdr_idx >= HDR_BYTES) begin
          hdr_idx = 0;
          if (rec_len_h == 16'd0) return close_record(r0, r1);
          scan_st = PH_PAYLOAD;
        end
        return 0;
      end
      PH_PAYLOAD: begin
        crc_acc = crc32_step(crc_acc, b);
        hdr_idx++;
        if (hdr_idx >= rec_len_h) return close_record(r0, r1);
        return 0;
      end
      default: return -1;
    endcase
  endfunction

  function automatic alrs_result_t typed_stop(input logic [24:0] ep, input logic [31:0] ns,
                                              input logic [24:0] cnt, input alrs_cause_t c);
    alrs_result_t r;
    r = '0;
    r.kind = 1'b1;
    r.end_pointer = ep;
    r.next_sequence = ns;
    r.valid_count = cnt;
    r.stop_cause = c;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_probe(input logic m, input logic [7:0] b, input int typed,
                           input alrs_result_t r);
    probe_t p;
    p.mode = m;
    p.data = b;
    p.typed = typed;
    p.res = r;
    probes.push_back(p);
  endtask

  // one request; a gap first in idling phases, valid held until taken
  task automatic send_req(input logic m, input logic [7:0] b, output int n,
                          output alrs_result_t r0, output alrs_result_t r1);
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_pct);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_byte_value <= b;
    do @(posedge clk); while (!in_ready);
    n = scan_step(m, b, r0, r1);
    if (n >= 0) n_items++;
  endtask

  task automatic keep_results(input int n, input alrs_result_t r0, input alrs_result_t r1);
    if (n > 0) pending_res.push_back(r0);
    if (n > 1) pending_res.push_back(r1);
    if (n > 0) n_results += n;
  endtask

  task automatic feed(input logic m, input logic [7:0] b);
    int n;
    alrs_result_t r0, r1;
    send_req(m, b, n, r0, r1);
    keep_results(n, r0, r1);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // cut > 0 sends only the first cut bytes of the record
  task automatic send_record(input logic [7:0] t, input logic [7:0] rsv, input logic [15:0] len,
                             input logic [31:0] seq, input bit corrupt, input int cut);
    logic [7:0] img[$];
    logic [7:0] body[$];
    logic [31:0] c;
    int stop;
    img = '{t, rsv, len[7:0], len[15:8], seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
    c = CRC_INIT;
    foreach (img[i]) c = crc32_step(c, img[i]);
    if (len <= PAYLOAD_MAX) begin
      repeat (len) begin
        body.push_back(8'($urandom));
        c = crc32_step(c, body[$]);
      end
    end
    c = ~c;
    if (corrupt) c = c ^ (32'd1 << $urandom_range(0, 31));
    img.push_back(c[7:0]);
    img.push_back(c[15:8]);
    img.push_back(c[23:16]);
    img.push_back(c[31:24]);
    foreach (body[i]) img.push_back(body[i]);
    stop = (cut > 0) ? cut : img.size();
    for (int i = 0; i < stop; i++) begin
      feed(1'b1, img[i]);
      if (scan_st == PH_IDLE) break;
    end
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 16'd0;
    if (r < 90) return 16'($urandom_range(1, 8));
    return 16'($urandom_range(9, 40));
  endfunction

  function automatic logic [31:0] pick_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'hFFFFFFFF;
    if (r < 20) return 32'($urandom_range(0, 3));
    if (r < 30) return 32'hFFFFFFF0 + 32'($urandom_range(0, 15));
    return $urandom;
  endfunction

  task automatic random_action();
    int r;
    logic [7:0] t;
    r = $urandom_range(0, 99);
    t = 8'($urandom);
    if (t == erase_mark) t = t ^ 8'h01;
    if (scan_st == PH_IDLE) begin
      // stray bytes with no scan are dropped by the block
      if (r < 12) repeat ($urandom_range(1, 3)) feed(1'b1, 8'($urandom));
      else feed(1'b0, 8'($urandom));
    end else if (r < 62) send_record(t, 8'd0, pick_len(), pick_seq(), 1'b0, 0);
    else if (r < 70) send_record(t, 8'd0, pick_len(), pick_seq(), 1'b1, 0);
    else if (r < 75) send_record(erase_mark, 8'd0, pick_len(), pick_seq(), 1'b0, 0);
    else if (r < 79) send_record(t, 8'($urandom_range(1, 255)), pick_len(), pick_seq(), 1'b0, 0);
    else if (r < 83)
      send_record(t, 8'd0, 16'($urandom_range(PAYLOAD_MAX + 1, 65535)), pick_seq(), 1'b0, 0);
    else if (r < 84) send_record(t, 8'd0, 16'(PAYLOAD_MAX), pick_seq(), 1'b0, 0);
    else if (r < 92) repeat ($urandom_range(1, 16)) feed(1'b1, 8'($urandom));
    else if (r < 96) begin
      send_record(t, 8'd0, pick_len(), pick_seq(), 1'b0, $urandom_range(1, 11));
      feed(1'b0, 8'($urandom));
    end else feed(1'b0, 8'($urandom));
  endtask

  // close out a running scan so the registers can be rewritten
  task automatic drain_scan();
    while (scan_st != PH_IDLE) begin
      if (scan_st == PH_HEADER && hdr_idx == HB_TYPE) feed(1'b1, erase_mark);
      else if (scan_st == PH_HEADER && hdr_idx == HB_RSVD) feed(1'b1, 8'h01);
      else feed(1'b1, 8'($urandom));
    end
  endtask

  task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] g);
    if (e !== g) begin
      $error("%s: expected %0h, got %0h", nm, e, g);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    alrs_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $error("result with nothing pending: kind %0d", out_kind);
        n_errors++;
      end else begin
        want = pending_res.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("rec_type", want.rec_type, out_rec_type);
        check_field("rec_seq", want.rec_seq, out_rec_seq);
        check_field("rec_len", want.rec_len, out_rec_len);
        check_field("rec_offset", want.rec_offset, out_rec_offset);
        check_field("end_pointer", want.end_pointer, out_end_pointer);
        check_field("next_sequence", want.next_sequence, out_next_sequence);
        check_field("valid_count", want.valid_count, out_valid_count);
        check_field("stop_cause", want.stop_cause, out_stop_cause);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL append_log_record_scanner");
      $finish;
    end
  end

  initial begin
    alrs_result_t none;
    alrs_result_t r0, r1;
    int n;
    int first;
    int budget;
    logic [24:0] psz;
    logic [7:0] mk;

    none = '0;
    add_probe(1'b1, 8'h5A, 0, none);   // byte before any scan
    add_probe(1'b0, 8'h00, 0, none);
    add_probe(1'b1, 8'hFF, 1, typed_stop(25'd0, 32'd1, 25'd0, CAUSE_ERASED));
    add_probe(1'b1, 8'h00, 0, none);   // byte after the summary
    add_probe(1'b0, 8'hC3, 0, none);
    add_probe(1'b1, 8'h00, 0, none);
    add_probe(1'b1, 8'h80, 1, typed_stop(25'd0, 32'd1, 25'd0, CAUSE_BAD_HEADER));
    add_probe(1'b0, 8'h00, 0, none);
    add_probe(1'b1, 8'hFE, 0, none);
    add_probe(1'b1, 8'h00, 0, none);
    add_probe(1'b1, 8'h01, 0, none);
    add_probe(1'b1, 8'h01, 1, typed_stop(25'd0, 32'd1, 25'd0, CAUSE_BAD_HEADER));
    add_probe(1'b0, 8'hFF, 0, none);
    add_probe(1'b1, 8'h07, 0, none);
    add_probe(1'b1, 8'h00, 0, none);
    add_probe(1'b1, 8'hFF, 0, none);
    add_probe(1'b1, 8'hFF, 1, typed_stop(25'd0, 32'd1, 25'd0, CAUSE_BAD_HEADER));
    add_probe(1'b0, 8'h00, 0, none);
    add_probe(1'b1, 8'h11, -1, none);
    add_probe(1'b1, 8'h00, -1, none);
    add_probe(1'b1, 8'h00, -1, none);
    add_probe(1'b1, 8'h00, -1, none);
    add_probe(1'b0, 8'h3C, 0, none);   // restart in the middle of a header
    add_probe(1'b1, 8'hFF, 1, typed_stop(25'd0, 32'd1, 25'd0, CAUSE_ERASED));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) begin
      send_req(probes[i].mode, probes[i].data, n, r0, r1);
      if (probes[i].typed < 0) keep_results(n, r0, r1);
      else if (probes[i].typed > 0) keep_results(1, probes[i].res, none);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_scan();
      idle_input();
      wait_drained();
      repeat (4) @(posedge clk);
      case (ph)
        0: begin psz = 25'd0; mk = 8'hA5; budget = 20; end
        1: begin psz = 25'd12; mk = 8'hFF; budget = 50; end
        2: begin psz = 25'd60; mk = 8'h00; budget = 30; end
        3: begin psz = 25'd16777216; mk = 8'hFF; budget = 40; end
        4: begin psz = 25'h1FFFFFF; mk = 8'($urandom); budget = 50; end
        default: begin psz = 25'(200 + $urandom_range(0, 300)); mk = 8'($urandom); budget = 50; end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= CFG_PARTITION_SIZE;
      cfg_wdata <= psz;
      @(posedge clk);
      cfg_index <= CFG_ERASED_MARKER;
      cfg_wdata <= {17'd0, mk};
      @(posedge clk);
      cfg_we <= 1'b0;
      part_len = psz;
      erase_mark = mk;
      @(posedge clk);

      if (ph == 5) begin
        tx_pct = 0;
        rx_pct <= 47;
      end else begin
        case (ph % 4)
          0: begin tx_pct = 0; rx_pct <= 0; end
          1: begin tx_pct = 47; rx_pct <= 0; end
          2: begin tx_pct = 0; rx_pct <= 47; end
          default: begin tx_pct = 27; rx_pct <= 27; end
        endcase
      end
      first = n_items;

      if (ph == 3) begin
        // receiver goes quiet while short records keep the result queue busy
        feed(1'b0, 8'h00);
        hold_ask <= hold_ask + 1;
        repeat (12) send_record(8'h42, 8'd0, 16'd0, pick_seq(), 1'b0, 0);
        idle_input();
        wait_drained();
        send_record(8'h24, 8'd0, 16'(PAYLOAD_MAX), 32'hFFFFFFFF, 1'b0, 0);
      end

      while (n_items - first < budget || (ph == 5 && n_results < 60)) random_action();
    end

    drain_scan();
    idle_input();
    wait_drained();
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("PASS append_log_record_scanner");
    else $display("FAIL append_log_record_scanner");
    $finish;
  end

endmodule

// ===== append_log_record_scanner.f =====
design/alrs_pkg.sv
design/alrs_out_queue.sv
design/append_log_record_scanner.sv
test/testbench.sv
